// ----- src/glp_pkg.sv -----
// Shared types and constants for the greedy label placer.
package glp_pkg;

  localparam int CoordW = 16;
  localparam int WidthW = 11;
  localparam int BandW  = 12;

  typedef enum logic [2:0] {
    ST_FILTERED = 3'd0,
    ST_HIDDEN   = 3'd1,
    ST_NO_ROOM  = 3'd2,
    ST_PLACED   = 3'd3,
    ST_IGNORED  = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    REG_ZOOM   = 2'd0,
    REG_HALF_W = 2'd1,
    REG_HALF_H = 2'd2,
    REG_FONT_H = 2'd3
  } reg_idx_t;

  // One stored label as it travels down the chain.
  typedef struct packed {
    logic signed [CoordW-1:0] left;
    logic signed [CoordW-1:0] top;
    logic [WidthW-1:0]        width;
    logic [BandW-1:0]         band;
  } label_t;

  // Candidate under test, broadcast to every cell.
  typedef struct packed {
    logic signed [17:0] cx;
    logic signed [17:0] cy;
    logic [WidthW-1:0]  w;
    logic [6:0]         fh;
    logic [BandW-1:0]   band;
  } probe_t;

  function automatic logic [15:0] weight_of(input logic [3:0] wc);
    logic [15:0] r;
    case (wc)
      4'd0:    r = 16'd9999;
      4'd1:    r = 16'd4200;
      4'd2:    r = 16'd3900;
      4'd3:    r = 16'd3600;
      4'd4:    r = 16'd3300;
      4'd5:    r = 16'd3000;
      4'd6:    r = 16'd2700;
      4'd7:    r = 16'd2400;
      4'd8:    r = 16'd2100;
      4'd9:    r = 16'd1800;
      4'd10:   r = 16'd1500;
      4'd11:   r = 16'd1200;
      4'd12:   r = 16'd900;
      4'd13:   r = 16'd400;
      4'd14:   r = 16'd200;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- src/glp_if.sv -----
// Valid/ready channel interfaces for marks, results and configuration writes.
interface glp_mark_if;
  logic               valid;
  logic               ready;
  logic               frame_start;
  logic signed [15:0] screen_x;
  logic signed [15:0] screen_y;
  logic               in_front;
  logic [3:0]         weight_class;
  logic               has_symbol;
  logic               is_selected;
  logic [10:0]        text_width;
  logic [7:0]         symbol_width;
  modport source (output valid, frame_start, screen_x, screen_y, in_front, weight_class,
                  has_symbol, is_selected, text_width, symbol_width, input ready);
  modport sink (input valid, frame_start, screen_x, screen_y, in_front, weight_class,
                has_symbol, is_selected, text_width, symbol_width, output ready);
endinterface

interface glp_result_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [15:0] label_x;
  logic signed [15:0] label_y;
  modport source (output valid, status, label_x, label_y, input ready);
  modport sink (input valid, status, label_x, label_y, output ready);
endinterface

interface glp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- src/glp_cell.sv -----
// One cell of the label chain: holds one stored label and tests it against the probe.
module glp_cell (
  input  logic            clk,
  input  logic            shift,
  input  glp_pkg::label_t prev,
  input  glp_pkg::probe_t probe,
  input  logic            live,
  output glp_pkg::label_t held,
  output logic            hit
);
  import glp_pkg::*;

  logic signed [18:0] l_end, p_end, l_bot, p_bot;
  logic signed [12:0] d;

  // Label register, shifted from the neighbour when a label is stored.
  always_ff @(posedge clk) begin
    if (shift) held <= prev;
  end

  // Half-open rectangle overlap within one row band of the probe.
  always_comb begin
    d     = $signed({1'b0, held.band}) - $signed({1'b0, probe.band});
    l_end = 19'(held.left) + 19'($signed({1'b0, held.width}));
    p_end = 19'(probe.cx) + 19'($signed({1'b0, probe.w}));
    l_bot = 19'(held.top) + 19'($signed({1'b0, probe.fh}));
    p_bot = 19'(probe.cy) + 19'($signed({1'b0, probe.fh}));
    hit = live && d >= -13'sd1 && d <= 13'sd1 &&
          19'(probe.cx) < l_end && 19'(held.left) < p_end &&
          19'(probe.cy) < l_bot && 19'(held.top) < p_bot;
  end

endmodule

// ----- src/glp_chain.sv -----
// Row of label cells with per-cell occupancy and a registered collision flag.
module glp_chain #(
  parameter int Depth = 100
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            push,
  input  glp_pkg::label_t new_label,
  input  glp_pkg::probe_t probe,
  output logic            collide
);
  import glp_pkg::*;

  label_t         held [Depth];
  label_t         prev [Depth];
  logic [Depth-1:0] live;
  logic [Depth-1:0] hit;

  // Newest label enters at cell 0; older ones move one cell along.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign prev[i] = new_label;
    end else begin : g_body
      assign prev[i] = held[i-1];
    end
    glp_cell u_cell (
      .clk(clk), .shift(push), .prev(prev[i]), .probe(probe),
      .live(live[i]), .held(held[i]), .hit(hit[i])
    );
  end

  // Occupancy: a thermometer of filled cells.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      live    <= '0;
      collide <= 1'b0;
    end else begin
      if (push) live <= (live << 1) | Depth'(1);
      collide <= |hit;
    end
  end

endmodule

// ----- src/greedy_label_placer.sv -----
// Top level of the greedy label placer: filter, candidate sequencer and label chain.
// Filtered, hidden or ignored marks are settled in the decide state; placement first runs the
// row band division, then tries up to four candidates, each through a wait and a check state.
// One mark at a time: the next is taken the cycle after its result has been accepted.
// Every stored label is tested in parallel by its own cell in the chain.
// Synchronous reset clears the label count, chain occupancy and result valid, and resets the configuration registers.
module greedy_label_placer #(
  parameter int MAX_LABELS = 100
) (
  input logic        clk,
  input logic        rst,
  glp_mark_if.sink   mark,
  glp_cfg_if.sink    cfg,
  glp_result_if.source result
);
  import glp_pkg::*;

  localparam int CntW = $clog2(MAX_LABELS + 1);

  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_PROBE, S_WAIT, S_CHECK, S_DONE} state_t;

  state_t              state;
  logic [15:0]         zoom_radius;
  logic [12:0]         half_width, half_height;
  logic [5:0]          font_height;
  logic [CntW-1:0]     count;
  logic [1:0]          cand;
  logic                mframe, mfront, msym, msel;
  logic signed [15:0]  mx, my;
  logic [3:0]          mwc;
  logic [10:0]         mtw;
  logic [7:0]          msw;
  logic [BandW-1:0]    band;
  logic [6:0]          fh;
  probe_t              probe;
  label_t              new_label;
  logic                push, clear, collide;
  logic signed [17:0]  xr, xl;
  logic [13:0]         bandh;
  logic [12:0]         rem, dvd;
  logic [3:0]          div_cnt;
  logic [13:0]         trial;

  assign fh       = (font_height == 6'd0) ? 7'd1 : {1'b0, font_height};
  assign mark.ready = (state == S_IDLE) && !result.valid;
  assign cfg.ready  = 1'b1;
  assign xr = 18'(mx) + 18'(msw >> 1) + 18'sd1;
  assign xl = 18'(mx) - 18'(mtw) - 18'(msw) + 18'(msw >> 1) - 18'sd1;

  assign probe.cx   = cand[1] ? xl : xr;
  assign probe.cy   = cand[0] ? 18'(my) - 18'(fh) : 18'(my);
  assign probe.w    = mtw;
  assign probe.fh   = fh;
  assign probe.band = band;
  assign new_label.left  = 16'(probe.cx);
  assign new_label.top   = 16'(probe.cy);
  assign new_label.width = mtw;
  assign new_label.band  = band;
  assign push  = (state == S_CHECK) && !collide;
  assign clear = (state == S_DECIDE) && mframe;
  assign bandh = 14'({fh, 1'b0});
  // Band of the mark row: restoring division of y by twice the font height,
  // one quotient bit a cycle over the low 13 bits of y.
  assign trial = {rem, dvd[12]};

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      zoom_radius <= 16'd0;
      half_width  <= 13'd320;
      half_height <= 13'd240;
      font_height <= 6'd13;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_ZOOM:   zoom_radius <= cfg.data;
        REG_HALF_W: half_width  <= cfg.data[12:0];
        REG_HALF_H: half_height <= cfg.data[12:0];
        REG_FONT_H: font_height <= cfg.data[5:0];
        default: ;
      endcase
    end
  end

  // Sequencer and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) result.valid <= 1'b0;
      unique case (state)
        S_IDLE: if (mark.valid && mark.ready) begin
          mframe <= mark.frame_start; mx <= mark.screen_x; my <= mark.screen_y;
          mfront <= mark.in_front; mwc <= mark.weight_class; msym <= mark.has_symbol;
          msel <= mark.is_selected; mtw <= mark.text_width; msw <= mark.symbol_width;
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          result.label_x <= '0;
          result.label_y <= '0;
          cand <= 2'd0;
          if (mframe) count <= '0;
          if (!mframe && count >= CntW'(MAX_LABELS)) begin
            result.status <= ST_IGNORED; state <= S_DONE;
          end else if (weight_of(mwc) > zoom_radius && msym && !msel) begin
            result.status <= ST_FILTERED; state <= S_DONE;
          end else if (!mfront || mx < 0 || 17'(mx) >= 17'({half_width, 1'b0}) ||
                       my < 0 || 17'(my) >= 17'({half_height, 1'b0})) begin
            result.status <= ST_HIDDEN; state <= S_DONE;
          end else begin
            rem <= '0; dvd <= 13'(my); band <= '0; div_cnt <= '0; state <= S_PROBE;
          end
        end
        S_PROBE: begin
          // One quotient bit a cycle, most significant first.
          if (trial >= bandh) begin
            rem  <= 13'(trial - bandh);
            band <= {band[BandW-2:0], 1'b1};
          end else begin
            rem  <= trial[12:0];
            band <= {band[BandW-2:0], 1'b0};
          end
          dvd     <= {dvd[11:0], 1'b0};
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 4'd12) state <= S_WAIT;
        end
        S_WAIT: state <= S_CHECK;
        S_CHECK: begin
          if (!collide) begin
            count <= count + 1'b1;
            result.status <= ST_PLACED;
            result.label_x <= 16'(probe.cx);
            result.label_y <= 16'(probe.cy);
            state <= S_DONE;
          end else if (cand == 2'd3) begin
            result.status <= ST_NO_ROOM; state <= S_DONE;
          end else begin
            cand <= cand + 1'b1; state <= S_WAIT;
          end
        end
        S_DONE: if (!result.valid) begin
          result.valid <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  glp_chain #(.Depth(MAX_LABELS)) u_chain (
    .clk(clk), .rst(rst), .clear(clear), .push(push),
    .new_label(new_label), .probe(probe), .collide(collide)
  );

  // A label is only stored while room remains.
  a_room: assert property (@(posedge clk) disable iff (rst)
    push |-> count < CntW'(MAX_LABELS)) else $error("store past label limit");
  // Placed results report a stored label.
  a_place: assert property (@(posedge clk) disable iff (rst)
    push |=> result.status == ST_PLACED) else $error("placement not reported");
  // No new mark while a result is pending.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !mark.ready) else $error("mark taken over pending result");

endmodule

// ----- bench/glp_test_if.sv -----
// Constants shared by the testbench.
package glp_test_pkg;
  localparam int RecvLongHold = 200;
endpackage

// ----- bench/greedy_label_placer_test.sv -----
// Testbench for the greedy label placer: directed and random marks checked against a local predictor.
module greedy_label_placer_test;
  import glp_pkg::*;
  import glp_test_pkg::*;

  localparam int MaxLabels = 100;
  localparam int WatchLimit = 5000;

  typedef struct packed {
    logic               frame_start;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic               in_front;
    logic [3:0]         weight_class;
    logic               has_symbol;
    logic               is_selected;
    logic [10:0]        text_width;
    logic [7:0]         symbol_width;
  } mark_t;

  typedef struct packed {
    status_t            status;
    logic signed [15:0] label_x;
    logic signed [15:0] label_y;
  } placement_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  glp_mark_if   mark ();
  glp_cfg_if    cfg ();
  glp_result_if result ();

  greedy_label_placer #(.MAX_LABELS(MaxLabels)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .mark   (mark),
    .cfg    (cfg),
    .result (result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: registers and the labels of the current frame
  int unsigned zoom_r, half_w, half_h, font_h;
  int          lab_left [MaxLabels];
  int          lab_top  [MaxLabels];
  int          lab_w    [MaxLabels];
  int          lab_band [MaxLabels];
  int          lab_count;

  placement_t  pending_placements[$];
  int          n_errors;
  int          n_results;
  int          n_sent;
  int          idle_cycles;
  bit          long_hold_req;
  bit          burst_mode;
  int          status_seen[5];

  function automatic int weight_limit(input logic [3:0] wc);
    int tbl[16] = '{9999, 4200, 3900, 3600, 3300, 3000, 2700, 2400,
                    2100, 1800, 1500, 1200, 900, 400, 200, 0};
    return tbl[wc];
  endfunction

  function automatic bit overlaps_any(input int lx, input int ty, input int w, input int h,
                                      input int band);
    int d;
    for (int i = 0; i < lab_count; i++) begin
      d = lab_band[i] - band;
      if (d >= -1 && d <= 1 &&
          lx < lab_left[i] + lab_w[i] && lab_left[i] < lx + w &&
          ty < lab_top[i] + h && lab_top[i] < ty + h) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Works out the placement for one mark and updates the stored labels
  function automatic placement_t place_label(input mark_t m);
    placement_t p;
    int x, y, fw, sw, fh, band, cx, cy;
    int xs[2];
    x  = m.screen_x;
    y  = m.screen_y;
    fw = m.text_width;
    sw = m.symbol_width;
    fh = (font_h == 0) ? 1 : font_h;
    p  = '{ST_NO_ROOM, 16'sd0, 16'sd0};
    if (m.frame_start) lab_count = 0;
    if (lab_count >= MaxLabels) begin
      p.status = ST_IGNORED;
    end else if (weight_limit(m.weight_class) > int'(zoom_r) && m.has_symbol &&
                 !m.is_selected) begin
      p.status = ST_FILTERED;
    end else if (!m.in_front || x < 0 || x >= int'(2 * half_w) ||
                 y < 0 || y >= int'(2 * half_h)) begin
      p.status = ST_HIDDEN;
    end else begin
      band  = y / (2 * fh);
      xs[0] = x + sw / 2 + 1;
      xs[1] = x - fw - sw + sw / 2 - 1;
      for (int k = 0; k < 4 && p.status == ST_NO_ROOM; k++) begin
        cx = xs[k >> 1];
        cy = (k & 1) ? y - fh : y;
        if (!overlaps_any(cx, cy, fw, fh, band)) begin
          lab_left[lab_count] = cx;
          lab_top[lab_count]  = cy;
          lab_w[lab_count]    = fw;
          lab_band[lab_count] = band;
          lab_count++;
          p = '{ST_PLACED, cx[15:0], cy[15:0]};
        end
      end
    end
    return p;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    n_errors++;
    $display("Mismatch on %s at result %0d: got %0d, want %0d", what, n_results, got, want);
  endtask

  // Sends one mark and queues its expected placement on acceptance; valid stays
  // high afterwards until a gap or a drain lowers it
  task automatic send_mark(input mark_t m);
    int gap;
    if (!burst_mode && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      mark.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    mark.valid        <= 1'b1;
    mark.frame_start  <= m.frame_start;
    mark.screen_x     <= m.screen_x;
    mark.screen_y     <= m.screen_y;
    mark.in_front     <= m.in_front;
    mark.weight_class <= m.weight_class;
    mark.has_symbol   <= m.has_symbol;
    mark.is_selected  <= m.is_selected;
    mark.text_width   <= m.text_width;
    mark.symbol_width <= m.symbol_width;
    do @(posedge clk); while (!mark.ready);
    pending_placements.push_back(place_label(m));
    n_sent++;
  endtask

  task automatic write_reg(input reg_idx_t idx, input int unsigned val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= val[15:0];
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_ZOOM:   zoom_r = val & 16'hFFFF;
      REG_HALF_W: half_w = val & 13'h1FFF;
      REG_HALF_H: half_h = val & 13'h1FFF;
      default:    font_h = val & 6'h3F;
    endcase
  endtask

  // Waits until every expected result has arrived, then a short settle
  task automatic drain;
    mark.valid <= 1'b0;
    while (pending_placements.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(input int unsigned zr, input int unsigned hw,
                            input int unsigned hh, input int unsigned fh);
    drain();
    write_reg(REG_ZOOM, zr);
    write_reg(REG_HALF_W, hw);
    write_reg(REG_HALF_H, hh);
    write_reg(REG_FONT_H, fh);
    cfg.valid <= 1'b0;
  endtask

  function automatic mark_t visible_mark(input bit fs);
    mark_t m;
    m.frame_start  = fs;
    m.screen_x     = 16'($urandom_range(0, 2 * half_w - 1));
    m.screen_y     = 16'($urandom_range(0, 2 * half_h - 1));
    m.in_front     = 1'b1;
    m.weight_class = 4'($urandom_range(0, 15));
    m.has_symbol   = 1'($urandom_range(0, 1));
    m.is_selected  = 1'($urandom_range(0, 1));
    m.text_width   = ($urandom_range(0, 7) == 0) ? 11'($urandom_range(0, 2047))
                                                 : 11'($urandom_range(0, 120));
    m.symbol_width = 8'($urandom_range(0, 255));
    return m;
  endfunction

  function automatic mark_t noise_mark();
    mark_t m;
    m.frame_start  = ($urandom_range(0, 15) == 0);
    m.screen_x     = 16'($urandom);
    m.screen_y     = 16'($urandom);
    m.in_front     = 1'($urandom);
    m.weight_class = 4'($urandom);
    m.has_symbol   = 1'($urandom);
    m.is_selected  = 1'($urandom);
    m.text_width   = 11'($urandom);
    m.symbol_width = 8'($urandom);
    return m;
  endfunction

  // Directed: field extremes, every status, zero width, zero font height, limit
  task automatic test_directed;
    mark_t m;
    set_config(0, 320, 240, 13);
    m = '{1'b1, 16'sd100, 16'sd100, 1'b1, 4'd15, 1'b1, 1'b0, 11'd40, 8'd10};
    send_mark(m);                                   // placed right
    send_mark(m);  m.frame_start = 1'b0;            // new frame, same again
    send_mark(m); send_mark(m); send_mark(m);       // right-up, left, left-up
    send_mark(m);                                   // no room
    m.weight_class = 4'd0; send_mark(m);            // filtered
    m.is_selected = 1'b1; send_mark(m);             // selected passes
    m.in_front = 1'b0; send_mark(m);                // behind globe
    m.in_front = 1'b1;
    m.screen_x = -16'sd32768; send_mark(m);
    m.screen_x = 16'sd32767;  send_mark(m);
    m.screen_x = 16'sd639; m.screen_y = 16'sd479; send_mark(m);
    m.screen_y = 16'sd480; send_mark(m);
    m.screen_y = -16'sd32768; send_mark(m);
    m.screen_y = 16'sd0; m.text_width = 11'd0; m.symbol_width = 8'd255; send_mark(m);
    m.text_width = 11'd2047; m.symbol_width = 8'd0; send_mark(m);
    set_config(65535, 4096, 4096, 0);
    m = '{1'b1, 16'sd8191, 16'sd8191, 1'b1, 4'd0, 1'b1, 1'b0, 11'd5, 8'd1};
    send_mark(m); send_mark(m);
    set_config(1000, 0, 240, 63);
    m.screen_x = 16'sd0; m.screen_y = 16'sd0; send_mark(m);
    // fill to the label limit, then two more are ignored
    set_config(0, 4096, 4096, 1);
    for (int i = 0; i < MaxLabels + 2; i++) begin
      m = '{(i == 0), 16'(i * 20), 16'(i * 40), 1'b1, 4'd15, 1'b0, 1'b0, 11'd3, 8'd0};
      send_mark(m);
    end
  endtask

  // Random frames of well-formed visible marks with some noise, over several settings
  task automatic test_random;
    int unsigned zr, hw, hh, fh;
    mark_t m;
    for (int ph = 0; ph < 6; ph++) begin
      zr = (ph == 0) ? 0 : (ph == 1) ? 65535 : $urandom_range(0, 10000);
      hw = (ph == 2) ? 1 : (ph == 3) ? 4096 : $urandom_range(20, 400);
      hh = (ph == 2) ? 1 : (ph == 3) ? 4096 : $urandom_range(20, 300);
      fh = (ph == 4) ? 63 : (ph == 2) ? 1 : $urandom_range(1, 30);
      set_config(zr, hw, hh, fh);
      for (int i = 0; i < 200; i++) begin
        burst_mode = ($urandom_range(0, 9) < 3);
        m = ($urandom_range(0, 9) < 8) ? visible_mark(i % 60 == 0) : noise_mark();
        send_mark(m);
      end
      burst_mode = 1'b0;
    end
  endtask

  // Receiver holds off while the sender keeps offering, then sender waits for drain
  task automatic test_backpressure;
    mark_t m;
    set_config(0, 320, 240, 13);
    long_hold_req = 1'b1;
    burst_mode = 1'b1;
    for (int i = 0; i < 30; i++) begin
      m = visible_mark(i == 0);
      send_mark(m);
    end
    burst_mode = 1'b0;
    drain();
  endtask

  // Result channel: stall pattern and checker
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else if (long_hold_req) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(0, 7) != 0) || (($urandom & 32'h300) == 0);
    end
  end

  initial begin
    long_hold_req = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        repeat (RecvLongHold) @(posedge clk);
        long_hold_req = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    placement_t want;
    if (!rst && result.valid && result.ready) begin
      n_results++;
      if (pending_placements.size() == 0) begin
        report_mismatch("unexpected result", result.status, -1);
      end else begin
        want = pending_placements.pop_front();
        status_seen[want.status]++;
        if (result.status != want.status)
          report_mismatch("status", result.status, want.status);
        if (result.label_x != want.label_x)
          report_mismatch("label_x", result.label_x, want.label_x);
        if (result.label_y != want.label_y)
          report_mismatch("label_y", result.label_y, want.label_y);
      end
    end
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (mark.valid && mark.ready) || (result.valid && result.ready) ||
        (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("Timeout with %0d results outstanding", pending_placements.size());
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    mark.valid = 1'b0;
    mark.frame_start = 1'b0; mark.screen_x = '0; mark.screen_y = '0;
    mark.in_front = 1'b0; mark.weight_class = '0; mark.has_symbol = 1'b0;
    mark.is_selected = 1'b0; mark.text_width = '0; mark.symbol_width = '0;
    cfg.valid = 1'b0; cfg.index = REG_ZOOM; cfg.data = '0;
    result.ready = 1'b0;
    idle_cycles = 0; n_errors = 0; n_results = 0; n_sent = 0; burst_mode = 1'b0;
    zoom_r = 0; half_w = 320; half_h = 240; font_h = 13; lab_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    drain();
    $display("Marks sent %0d, results checked %0d", n_sent, n_results);
    $display("Outcomes: filtered %0d hidden %0d no room %0d placed %0d ignored %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4]);
    if (n_errors == 0 && pending_placements.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
